>>> hdl/cgr_pkg.sv
// ----------------------------------------------------------------------------
// cgr_pkg: shared types and constants of the clipped glyph row renderer
// Glyph store geometry, field widths, command and register codes, sequencer
// states and the structs that pass between the renderer's modules.
// ----------------------------------------------------------------------------
package cgr_pkg;

  // Glyph geometry
  localparam int GLYPH_ROWS  = 12;
  localparam int GLYPH_COUNT = 128;
  localparam int GLYPH_COLS  = 8;

  // Field widths
  localparam int POS_W       = 16;
  localparam int XY_W        = POS_W + 1;   // exact sum of position and translation
  localparam int SUM_W       = POS_W + 2;   // difference of a translated value and a clip edge
  localparam int COLOR_W     = 32;
  localparam int CODE_W      = 8;
  localparam int CODE_MASK_W = 7;
  localparam int LOAD_ROW_W  = 4;
  localparam int BITS_W      = 8;

  // Glyph store
  localparam int ROW_W       = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int STORE_DEPTH = GLYPH_ROWS * GLYPH_COUNT;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Configuration port
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X = 1'b0,
    REG_OFFSET_Y = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XSUM,
    ST_YSUM,
    ST_RIGHT,
    ST_LEFT,
    ST_BOTTOM,
    ST_TOP,
    ST_ROW
  } st_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [CODE_W-1:0]       glyph_code;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [COLOR_W-1:0]      color;
    logic signed [POS_W-1:0] clip_left;
    logic signed [POS_W-1:0] clip_top;
    logic signed [POS_W-1:0] clip_right;
    logic signed [POS_W-1:0] clip_bottom;
    logic [LOAD_ROW_W-1:0]   load_row;
    logic [BITS_W-1:0]       load_bits;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] row_x;
    logic signed [POS_W-1:0] row_y;
    logic [BITS_W-1:0]       pixel_mask;
    logic [COLOR_W-1:0]      pixel_color;
    logic                    last;
  } out_item_t;

  // Operands of the shared adder/subtractor
  typedef struct packed {
    logic signed [SUM_W-1:0] a;
    logic signed [SUM_W-1:0] b;
    logic                    sub;
  } alu_op_t;

  // Glyph store access
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BITS_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Result handed to the output register
  typedef struct packed {
    logic      load;
    out_item_t item;
  } emit_t;

  // Store entry of one glyph row: row * GLYPH_COUNT + code
  function automatic logic [ADDR_W-1:0] glyph_addr(input int unsigned row,
                                                   input logic [CODE_MASK_W-1:0] code);
    return ADDR_W'(row * GLYPH_COUNT + int'(code));
  endfunction

  // Sign-extend a 16-bit position to the adder width
  function automatic logic signed [SUM_W-1:0] sx_pos(input logic signed [POS_W-1:0] v);
    return SUM_W'(v);
  endfunction

endpackage

>>> hdl/cgr_in_if.sv
// ----------------------------------------------------------------------------
// cgr_in_if: input item channel of the clipped glyph row renderer
// Valid/ready channel carrying one load or draw item per transfer.
// ----------------------------------------------------------------------------
interface cgr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  cmd;
  logic [cgr_pkg::CODE_W-1:0]            glyph_code;
  logic signed [cgr_pkg::POS_W-1:0]      pos_x;
  logic signed [cgr_pkg::POS_W-1:0]      pos_y;
  logic [cgr_pkg::COLOR_W-1:0]           color;
  logic signed [cgr_pkg::POS_W-1:0]      clip_left;
  logic signed [cgr_pkg::POS_W-1:0]      clip_top;
  logic signed [cgr_pkg::POS_W-1:0]      clip_right;
  logic signed [cgr_pkg::POS_W-1:0]      clip_bottom;
  logic [cgr_pkg::LOAD_ROW_W-1:0]        load_row;
  logic [cgr_pkg::BITS_W-1:0]            load_bits;

  modport source (
    output valid, cmd, glyph_code, pos_x, pos_y, color,
           clip_left, clip_top, clip_right, clip_bottom, load_row, load_bits,
    input  ready
  );

  modport sink (
    input  valid, cmd, glyph_code, pos_x, pos_y, color,
           clip_left, clip_top, clip_right, clip_bottom, load_row, load_bits,
    output ready
  );
endinterface

>>> hdl/cgr_out_if.sv
// ----------------------------------------------------------------------------
// cgr_out_if: result channel of the clipped glyph row renderer
// Valid/ready channel carrying one rendered glyph row per transfer.
// ----------------------------------------------------------------------------
interface cgr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cgr_pkg::POS_W-1:0] row_x;
  logic signed [cgr_pkg::POS_W-1:0] row_y;
  logic [cgr_pkg::BITS_W-1:0]       pixel_mask;
  logic [cgr_pkg::COLOR_W-1:0]      pixel_color;
  logic                             last;

  modport source (
    output valid, row_x, row_y, pixel_mask, pixel_color, last,
    input  ready
  );

  modport sink (
    input  valid, row_x, row_y, pixel_mask, pixel_color, last,
    output ready
  );
endinterface

>>> hdl/cgr_glyph_ram.sv
// ----------------------------------------------------------------------------
// cgr_glyph_ram: font glyph store
// One write port and one read port with registered read data. Entries are
// undefined until loaded.
// ----------------------------------------------------------------------------
module cgr_glyph_ram (
  input  logic                          clk,
  input  cgr_pkg::ram_req_t             req,
  output logic [cgr_pkg::BITS_W-1:0]    rdata
);

  logic [cgr_pkg::BITS_W-1:0] mem [cgr_pkg::STORE_DEPTH];

  // Write one font row byte
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read every cycle into the registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

>>> hdl/cgr_addsub.sv
// ----------------------------------------------------------------------------
// cgr_addsub: shared adder/subtractor
// Single carry chain computing a + b or a - b for every sequencer step.
// ----------------------------------------------------------------------------
module cgr_addsub (
  input  cgr_pkg::alu_op_t                 op,
  output logic signed [cgr_pkg::SUM_W-1:0] sum
);

  logic [cgr_pkg::SUM_W-1:0] b_inv;

  // Invert b and inject carry to subtract
  assign b_inv = op.b ^ {cgr_pkg::SUM_W{op.sub}};
  assign sum   = op.a + b_inv + cgr_pkg::SUM_W'(op.sub);

endmodule

>>> hdl/cgr_ctrl.sv
// ----------------------------------------------------------------------------
// cgr_ctrl: draw sequencer of the clipped glyph row renderer
// Writes load items into the glyph store. A draw item steps the shared adder
// through translation and clip tests, then emits a row per cycle if unstalled.
// ----------------------------------------------------------------------------
module cgr_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  cgr_pkg::in_item_t                    in_item,
  input  logic signed [cgr_pkg::POS_W-1:0]     offset_x,
  input  logic signed [cgr_pkg::POS_W-1:0]     offset_y,
  output cgr_pkg::alu_op_t                     alu_op,
  input  logic signed [cgr_pkg::SUM_W-1:0]     alu_sum,
  output cgr_pkg::ram_req_t                    ram_req,
  input  logic [cgr_pkg::BITS_W-1:0]           ram_q,
  input  logic                                 out_free,
  output cgr_pkg::emit_t                       emit
);

  cgr_pkg::st_t                     state_r, state_nxt;
  cgr_pkg::in_item_t                item_r, item_nxt;
  logic signed [cgr_pkg::XY_W-1:0]  x_r, x_nxt;
  logic signed [cgr_pkg::XY_W-1:0]  y_r, y_nxt;
  logic [cgr_pkg::GLYPH_COLS-1:0]   colhi_r, colhi_nxt;
  logic [cgr_pkg::GLYPH_COLS-1:0]   colmask_r, colmask_nxt;
  logic [cgr_pkg::ROW_W-1:0]        last_row_r, last_row_nxt;
  logic [cgr_pkg::ROW_W-1:0]        cur_row_r, cur_row_nxt;

  logic                             reject;
  logic                             empty;
  logic                             row_done;
  logic                             code_ok;
  logic [cgr_pkg::ROW_W-1:0]        first_row;
  logic [cgr_pkg::CODE_MASK_W-1:0]  in_code;
  logic [cgr_pkg::CODE_MASK_W-1:0]  draw_code;

  assign in_code   = in_item.glyph_code[cgr_pkg::CODE_MASK_W-1:0];
  assign draw_code = item_r.glyph_code[cgr_pkg::CODE_MASK_W-1:0];
  assign code_ok   = (int'(draw_code) < cgr_pkg::GLYPH_COUNT);
  assign row_done  = (cur_row_r == last_row_r);

  // Decode clip test outcomes from the shared adder
  always_comb begin
    reject    = 1'b0;
    first_row = '0;
    if (alu_sum[cgr_pkg::SUM_W-1]) begin
      first_row = cgr_pkg::ROW_W'(-alu_sum);
    end
    unique case (state_r)
      cgr_pkg::ST_RIGHT:  reject = alu_sum[cgr_pkg::SUM_W-1];
      cgr_pkg::ST_LEFT:
        reject = (alu_sum < $signed(cgr_pkg::SUM_W'(-(cgr_pkg::GLYPH_COLS - 1))));
      cgr_pkg::ST_BOTTOM: reject = alu_sum[cgr_pkg::SUM_W-1];
      cgr_pkg::ST_TOP:
        reject = (alu_sum < $signed(cgr_pkg::SUM_W'(-(cgr_pkg::GLYPH_ROWS - 1))));
      default:            reject = 1'b0;
    endcase
    empty = (first_row > last_row_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cgr_pkg::ST_IDLE: begin
        if (in_valid && (in_item.cmd == cgr_pkg::CMD_DRAW)) begin
          state_nxt = cgr_pkg::ST_XSUM;
        end
      end
      cgr_pkg::ST_XSUM:   state_nxt = cgr_pkg::ST_YSUM;
      cgr_pkg::ST_YSUM:   state_nxt = cgr_pkg::ST_RIGHT;
      cgr_pkg::ST_RIGHT:  state_nxt = reject ? cgr_pkg::ST_IDLE : cgr_pkg::ST_LEFT;
      cgr_pkg::ST_LEFT:   state_nxt = reject ? cgr_pkg::ST_IDLE : cgr_pkg::ST_BOTTOM;
      cgr_pkg::ST_BOTTOM: state_nxt = reject ? cgr_pkg::ST_IDLE : cgr_pkg::ST_TOP;
      cgr_pkg::ST_TOP: begin
        state_nxt = (reject || empty) ? cgr_pkg::ST_IDLE : cgr_pkg::ST_ROW;
      end
      cgr_pkg::ST_ROW: begin
        if (out_free && row_done) begin
          state_nxt = cgr_pkg::ST_IDLE;
        end
      end
      default:            state_nxt = cgr_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    in_ready      = 1'b0;
    alu_op        = '0;
    emit          = '0;
    ram_req       = '0;
    item_nxt      = item_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    colhi_nxt     = colhi_r;
    colmask_nxt   = colmask_r;
    last_row_nxt  = last_row_r;
    cur_row_nxt   = cur_row_r;

    unique case (state_r)
      cgr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt = in_item;
        end
        // Store a font row byte on a load transfer
        ram_req.we    = in_valid && (in_item.cmd == cgr_pkg::CMD_LOAD) &&
                        (int'(in_item.load_row) < cgr_pkg::GLYPH_ROWS) &&
                        (int'(in_code) < cgr_pkg::GLYPH_COUNT);
        ram_req.waddr = cgr_pkg::glyph_addr(32'(in_item.load_row), in_code);
        ram_req.wdata = in_item.load_bits;
      end
      cgr_pkg::ST_XSUM: begin
        alu_op.a = cgr_pkg::sx_pos(item_r.pos_x);
        alu_op.b = cgr_pkg::sx_pos(offset_x);
        x_nxt    = alu_sum[cgr_pkg::XY_W-1:0];
      end
      cgr_pkg::ST_YSUM: begin
        alu_op.a = cgr_pkg::sx_pos(item_r.pos_y);
        alu_op.b = cgr_pkg::sx_pos(offset_y);
        y_nxt    = alu_sum[cgr_pkg::XY_W-1:0];
      end
      cgr_pkg::ST_RIGHT: begin
        // Column i is visible on the right side when i <= right - x
        alu_op.a   = cgr_pkg::sx_pos(item_r.clip_right);
        alu_op.b   = cgr_pkg::SUM_W'(x_r);
        alu_op.sub = 1'b1;
        for (int i = 0; i < cgr_pkg::GLYPH_COLS; i++) begin
          colhi_nxt[cgr_pkg::GLYPH_COLS-1-i] = (alu_sum >= $signed(cgr_pkg::SUM_W'(i)));
        end
      end
      cgr_pkg::ST_LEFT: begin
        // Column i is visible on the left side when x - left >= -i
        alu_op.a   = cgr_pkg::SUM_W'(x_r);
        alu_op.b   = cgr_pkg::sx_pos(item_r.clip_left);
        alu_op.sub = 1'b1;
        for (int i = 0; i < cgr_pkg::GLYPH_COLS; i++) begin
          colmask_nxt[cgr_pkg::GLYPH_COLS-1-i] = colhi_r[cgr_pkg::GLYPH_COLS-1-i] &&
            (alu_sum >= $signed(cgr_pkg::SUM_W'(-i)));
        end
      end
      cgr_pkg::ST_BOTTOM: begin
        // Last visible row: bottom - y, capped at the last glyph row
        alu_op.a   = cgr_pkg::sx_pos(item_r.clip_bottom);
        alu_op.b   = cgr_pkg::SUM_W'(y_r);
        alu_op.sub = 1'b1;
        if (alu_sum >= $signed(cgr_pkg::SUM_W'(cgr_pkg::GLYPH_ROWS - 1))) begin
          last_row_nxt = cgr_pkg::ROW_W'(cgr_pkg::GLYPH_ROWS - 1);
        end else begin
          last_row_nxt = alu_sum[cgr_pkg::ROW_W-1:0];
        end
      end
      cgr_pkg::ST_TOP: begin
        // First visible row: top - y when the glyph starts above the clip
        alu_op.a    = cgr_pkg::SUM_W'(y_r);
        alu_op.b    = cgr_pkg::sx_pos(item_r.clip_top);
        alu_op.sub  = 1'b1;
        cur_row_nxt = first_row;
      end
      cgr_pkg::ST_ROW: begin
        // Emit the current row and advance when the output register frees
        alu_op.a                    = cgr_pkg::SUM_W'(y_r);
        alu_op.b                    = cgr_pkg::SUM_W'(cur_row_r);
        emit.load                   = out_free;
        emit.item.row_x             = x_r[cgr_pkg::POS_W-1:0];
        emit.item.row_y             = alu_sum[cgr_pkg::POS_W-1:0];
        emit.item.pixel_mask        = code_ok ? (ram_q & colmask_r) : '0;
        emit.item.pixel_color       = item_r.color;
        emit.item.last              = row_done;
        if (out_free && !row_done) begin
          cur_row_nxt = cur_row_r + 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase

    // Read the row that will be current next cycle
    ram_req.raddr = cgr_pkg::glyph_addr(32'(cur_row_nxt), draw_code);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cgr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    colhi_r    <= colhi_nxt;
    colmask_r  <= colmask_nxt;
    last_row_r <= last_row_nxt;
    cur_row_r  <= cur_row_nxt;
  end

endmodule

>>> hdl/clipped_glyph_row_renderer.sv
// ----------------------------------------------------------------------------
// clipped_glyph_row_renderer: 8x12 bitmap-font glyph renderer with clipping
// Loads font rows into a glyph store and renders one character per draw item
// as clipped rows with pixel masks.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries load and draw items; a transfer takes place when valid
//   and ready are both high. A load item with load_row below 12 writes one
//   font row byte in the transfer cycle and the block is ready again the
//   next cycle. A draw item is translated by the offset_x/offset_y
//   registers (the user writes them through cfg_we/cfg_index/cfg_data only
//   while idle; the block does not enforce this) and clipped. The shared
//   adder then runs six steps (two translation sums, four clip edge tests)
//   before the first row is written to the output register; further rows
//   follow one per cycle while out_chan is not stalled. A fully clipped
//   glyph yields no transfer. in_chan.ready stays low during a draw.
//   Results sit in an output register; when it is full and out_chan.ready
//   is low the row sequencer holds, and the glyph store read is repeated
//   until it moves. Reset clears the sequencer, the output valid and both
//   translations; the glyph store is undefined until loaded.
// ----------------------------------------------------------------------------
module clipped_glyph_row_renderer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cgr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cgr_pkg::CFG_DATA_W-1:0]      cfg_data,
  cgr_in_if.sink                              in_chan,
  cgr_out_if.source                           out_chan
);

  logic signed [cgr_pkg::POS_W-1:0]  offset_x_r;
  logic signed [cgr_pkg::POS_W-1:0]  offset_y_r;
  logic                              out_valid_r;
  cgr_pkg::out_item_t                out_r;

  cgr_pkg::in_item_t                 in_item;
  cgr_pkg::alu_op_t                  alu_op;
  logic signed [cgr_pkg::SUM_W-1:0]  alu_sum;
  cgr_pkg::ram_req_t                 ram_req;
  logic [cgr_pkg::BITS_W-1:0]        ram_q;
  cgr_pkg::emit_t                    emit;
  logic                              out_free;

  // Gather the input payload
  always_comb begin
    in_item.cmd         = cgr_pkg::cmd_t'(in_chan.cmd);
    in_item.glyph_code  = in_chan.glyph_code;
    in_item.pos_x       = in_chan.pos_x;
    in_item.pos_y       = in_chan.pos_y;
    in_item.color       = in_chan.color;
    in_item.clip_left   = in_chan.clip_left;
    in_item.clip_top    = in_chan.clip_top;
    in_item.clip_right  = in_chan.clip_right;
    in_item.clip_bottom = in_chan.clip_bottom;
    in_item.load_row    = in_chan.load_row;
    in_item.load_bits   = in_chan.load_bits;
  end

  // Translation registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= '0;
      offset_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cgr_pkg::cfg_reg_t'(cfg_index))
        cgr_pkg::REG_OFFSET_X: offset_x_r <= cfg_data;
        cgr_pkg::REG_OFFSET_Y: offset_y_r <= cfg_data;
      endcase
    end
  end

  cgr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_item     (in_item),
    .offset_x    (offset_x_r),
    .offset_y    (offset_y_r),
    .alu_op      (alu_op),
    .alu_sum     (alu_sum),
    .ram_req     (ram_req),
    .ram_q       (ram_q),
    .out_free    (out_free),
    .emit        (emit)
  );

  cgr_addsub u_addsub (
    .op  (alu_op),
    .sum (alu_sum)
  );

  cgr_glyph_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_q)
  );

  // Output register: free when empty or being taken this cycle
  assign out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_r <= emit.item;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.row_x       = out_r.row_x;
  assign out_chan.row_y       = out_r.row_y;
  assign out_chan.pixel_mask  = out_r.pixel_mask;
  assign out_chan.pixel_color = out_r.pixel_color;
  assign out_chan.last        = out_r.last;

endmodule
